// File: src/rft_pkg.sv
// Shared types and constants of the rail fence transposer.
`default_nettype none

package rft_pkg;

    // Fixed field widths.
    localparam int CHAR_W  = 8;
    localparam int RAILS_W = 5;

    // Defaults of the top-level parameters.
    localparam int MAX_LEN_DEF   = 64;
    localparam int MAX_RAILS_DEF = 16;

    // Configuration port.
    localparam int APB_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    // Register indexes, decoded from the word address bit of paddr.
    localparam logic REG_RAILS = 1'b0;
    localparam logic REG_MODE  = 1'b1;

    // Register reset values.
    localparam logic [RAILS_W-1:0] RAILS_RST = 5'd3;
    localparam logic               MODE_RST  = 1'b0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;         // a word is accepted this cycle
        logic burst_start;  // the accepted word closes a nonempty message
        logic walk_step;    // one step of the zigzag walk
        logic scan_step;    // one step of the linear read of the decrypt buffer
    } rft_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic burst_ready;  // the message is nonempty once the current word is stored
        logic decrypt;      // mode captured at the start of the burst
        logic last_step;    // the step counter is on the final position
    } rft_status_t;

endpackage

`default_nettype wire

// File: src/rft_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: src/rft_ctrl.sv
// Controller state machine of the rail fence transposer.
`default_nettype none

module rft_ctrl
    import rft_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        last_in,
    input  wire rft_status_t st,
    output logic             busy,
    output rft_cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_WALK   = 4'b0010,
        S_SETTLE = 4'b0100,
        S_SCAN   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    always_comb
    begin
        cmd.load        = accept;
        cmd.burst_start = accept && last_in && st.burst_ready;
        cmd.walk_step   = (state_reg == S_WALK);
        cmd.scan_step   = (state_reg == S_SCAN);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.burst_start)
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (st.last_step)
                begin
                    state_next = st.decrypt ? S_SETTLE : S_IDLE;
                end
            end
            S_SETTLE:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (st.last_step)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: src/rft_datapath.sv
// Datapath: message store, zigzag walk, decrypt buffer and result register.
`default_nettype none

module rft_datapath
    import rft_pkg::*;
#(
    parameter int MAX_LEN   = MAX_LEN_DEF,
    parameter int MAX_RAILS = MAX_RAILS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rft_cmd_t           cmd,
    output rft_status_t             st,
    input  wire logic [CHAR_W-1:0]  char_in,
    input  wire logic               last_in,
    input  wire logic [RAILS_W-1:0] rails,
    input  wire logic               decrypt_mode,
    output logic [CHAR_W-1:0]       char_out,
    output logic                    last_out,
    output logic                    out_valid
);

    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int ADDR_W = $clog2(MAX_LEN);
    localparam int STEP_W = RAILS_W + 1;
    localparam int SUM_W  = ((LEN_W > STEP_W) ? LEN_W : STEP_W) + 1;

    // Loading and burst bookkeeping.
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LEN_W-1:0]   n_reg, n_next;
    logic [RAILS_W-1:0] k_reg, k_next;
    logic               dec_reg, dec_next;

    // Zigzag walk.
    logic [RAILS_W-1:0] rail_reg, rail_next;
    logic [LEN_W-1:0]   pos_reg, pos_next;
    logic               phase_reg, phase_next;
    logic [LEN_W-1:0]   cnt_reg, cnt_next;

    // Read pipeline and decrypt scatter write.
    logic               rd_valid_reg, rd_last_reg, rd_src_reg;
    logic               scat_pend_reg;
    logic [ADDR_W-1:0]  scat_addr_reg;

    // Result register.
    logic               out_valid_reg, last_out_reg;
    logic [CHAR_W-1:0]  char_out_reg;

    logic               store_ok;
    logic [LEN_W-1:0]   len_new;
    logic [RAILS_W-1:0] k_sat;
    logic [RAILS_W-1:0] k_m1;
    logic [STEP_W-1:0]  step;
    logic [SUM_W-1:0]   cand;
    logic               in_range;
    logic [ADDR_W-1:0]  msg_rd_addr;
    logic [CHAR_W-1:0]  msg_rd_data;
    logic [CHAR_W-1:0]  buf_rd_data;

    assign store_ok = (char_in != '0) && (len_reg < LEN_W'(MAX_LEN));
    assign len_new  = len_reg + LEN_W'(store_ok);

    // Zero rails act as one rail; the count saturates at the largest supported.
    always_comb
    begin
        if (rails == '0)
        begin
            k_sat = RAILS_W'(1);
        end
        else if (32'(rails) > MAX_RAILS)
        begin
            k_sat = RAILS_W'(MAX_RAILS);
        end
        else
        begin
            k_sat = rails;
        end
    end

    // Stride to the next position on the same rail. The top and bottom rails
    // stride by a whole period; inner rails alternate between the two legs.
    assign k_m1 = k_reg - RAILS_W'(1);
    always_comb
    begin
        priority if (k_reg == RAILS_W'(1))
        begin
            step = STEP_W'(1);
        end
        else if ((rail_reg == '0) || (rail_reg == k_m1))
        begin
            step = {k_m1, 1'b0};
        end
        else if (phase_reg)
        begin
            step = {rail_reg, 1'b0};
        end
        else
        begin
            step = {k_m1 - rail_reg, 1'b0};
        end
    end

    assign cand     = SUM_W'(pos_reg) + SUM_W'(step);
    assign in_range = cand < SUM_W'(n_reg);

    assign st.burst_ready = (len_new != '0);
    assign st.decrypt     = dec_reg;
    assign st.last_step   = (cnt_reg == (n_reg - LEN_W'(1)));

    always_comb
    begin
        len_next   = len_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        dec_next   = dec_reg;
        rail_next  = rail_reg;
        pos_next   = pos_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;

        if (cmd.load)
        begin
            len_next = last_in ? '0 : len_new;
        end

        if (cmd.burst_start)
        begin
            n_next     = len_new;
            k_next     = k_sat;
            dec_next   = decrypt_mode;
            rail_next  = '0;
            pos_next   = '0;
            phase_next = 1'b0;
            cnt_next   = '0;
        end
        else if (cmd.walk_step)
        begin
            cnt_next = st.last_step ? '0 : cnt_reg + LEN_W'(1);
            if (in_range)
            begin
                pos_next   = LEN_W'(cand);
                phase_next = !phase_reg;
            end
            else
            begin
                rail_next  = rail_reg + RAILS_W'(1);
                pos_next   = LEN_W'(SUM_W'(rail_reg) + SUM_W'(1));
                phase_next = 1'b0;
            end
        end
        else if (cmd.scan_step)
        begin
            cnt_next = cnt_reg + LEN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            n_reg         <= '0;
            k_reg         <= RAILS_W'(1);
            dec_reg       <= 1'b0;
            rail_reg      <= '0;
            pos_reg       <= '0;
            phase_reg     <= 1'b0;
            cnt_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            scat_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            dec_reg       <= dec_next;
            rail_reg      <= rail_next;
            pos_reg       <= pos_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            rd_valid_reg  <= (cmd.walk_step && !dec_reg) || cmd.scan_step;
            scat_pend_reg <= cmd.walk_step && dec_reg;
            out_valid_reg <= rd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_last_reg   <= st.last_step;
        rd_src_reg    <= cmd.scan_step;
        scat_addr_reg <= pos_reg[ADDR_W-1:0];
        char_out_reg  <= rd_src_reg ? buf_rd_data : msg_rd_data;
        last_out_reg  <= rd_valid_reg && rd_last_reg;
    end

    // Encrypt gathers from the walk position; decrypt reads in arrival order.
    assign msg_rd_addr = (cmd.walk_step && !dec_reg) ? pos_reg[ADDR_W-1:0]
                                                     : cnt_reg[ADDR_W-1:0];

    rft_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_LEN)
    ) u_msg_ram (
        .clk     (clk),
        .wr_en   (cmd.load && store_ok),
        .wr_addr (len_reg[ADDR_W-1:0]),
        .wr_data (char_in),
        .rd_addr (msg_rd_addr),
        .rd_data (msg_rd_data)
    );

    // Decrypt scatters each arriving byte to its zigzag position here.
    rft_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_LEN)
    ) u_buf_ram (
        .clk     (clk),
        .wr_en   (scat_pend_reg),
        .wr_addr (scat_addr_reg),
        .wr_data (msg_rd_data),
        .rd_addr (cnt_reg[ADDR_W-1:0]),
        .rd_data (buf_rd_data)
    );

    assign char_out  = char_out_reg;
    assign last_out  = last_out_reg;
    assign out_valid = out_valid_reg;

    // The last scatter write must land before the linear read starts.
    a_no_scan_during_scatter: assert property (@(posedge clk) disable iff (!rst_n)
        !(scat_pend_reg && cmd.scan_step))
        else $error("decrypt buffer read while a scatter write is pending");

    // The step counter never runs past the message.
    a_cnt_in_message: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.walk_step || cmd.scan_step) |-> (cnt_reg < n_reg))
        else $error("step counter beyond message length");

    // The walk only visits positions inside the message.
    a_pos_in_message: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_step |-> (pos_reg < n_reg))
        else $error("zigzag position beyond message length");

    // The final step's word leaves the result register marked by last_out.
    a_last_follows_step: assert property (@(posedge clk) disable iff (!rst_n)
        ((cmd.walk_step && !dec_reg && st.last_step) ||
         (cmd.scan_step && st.last_step)) |=> ##1 (out_valid_reg && last_out_reg))
        else $error("final word of burst not flagged");

endmodule

`default_nettype wire

// File: src/rail_fence_transposer_unit.sv
// Top level of the rail fence transposer: register port, controller, datapath.
`default_nettype none

// The unit applies a zigzag (rail fence) transposition to a message of up to
// MAX_LEN bytes. A word is accepted at each rising edge where start is high
// and busy is low, one word per cycle while loading; zero bytes are dropped
// and bytes past MAX_LEN are dropped as well. The word marked by last_in
// closes the message: if it is nonempty, busy rises and the permuted message
// comes out as a burst of words, one per cycle, each marked by out_valid for
// a single cycle, with last_out on the final one. The receiver cannot hold
// results off. In encrypt mode busy stays high after the last word while
// the walk takes one zigzag step per byte, and each result passes the read
// register and then the result register behind its step. In decrypt mode the
// zigzag walk first scatters the bytes into a second buffer, a settling state
// follows, and a linear read of that buffer gives the results, with busy
// high throughout. The read port of each message memory delivers one byte
// per cycle. The rail count and mode are sampled when the closing word is
// accepted; rail counts of zero act as one, counts above MAX_RAILS
// saturate, and one rail, or at least as many rails as bytes, leaves the
// message unchanged. A message that is empty when it is closed produces no
// results. Registers: rails at byte address 0 (reset 3) and decrypt_mode at
// byte address 4 (reset 0).

module rail_fence_transposer_unit
    import rft_pkg::*;
#(
    parameter int MAX_LEN   = MAX_LEN_DEF,
    parameter int MAX_RAILS = MAX_RAILS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Command channel.
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [CHAR_W-1:0]     char_in,
    input  wire logic                  last_in,
    // Result channel.
    output logic                       out_valid,
    output logic [CHAR_W-1:0]          char_out,
    output logic                       last_out,
    // Configuration port.
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    logic [RAILS_W-1:0] rails_reg, rails_next;
    logic               decrypt_mode_reg, decrypt_mode_next;
    logic               cfg_wr;
    logic               reg_sel;
    rft_cmd_t           cmd;
    rft_status_t        st;

    // The port never inserts wait states.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Registers sit on word boundaries, so the word address bit picks one.
    assign reg_sel = paddr[CFG_ADDR_W-1];

    always_comb
    begin
        rails_next        = rails_reg;
        decrypt_mode_next = decrypt_mode_reg;
        if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_RAILS: rails_next        = pwdata[RAILS_W-1:0];
                REG_MODE:  decrypt_mode_next = pwdata[0];
                default:   rails_next        = rails_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rails_reg        <= RAILS_RST;
            decrypt_mode_reg <= MODE_RST;
        end
        else
        begin
            rails_reg        <= rails_next;
            decrypt_mode_reg <= decrypt_mode_next;
        end
    end

    // Read data is returned in the access cycle.
    always_comb
    begin
        unique case (reg_sel)
            REG_RAILS: prdata = APB_DATA_W'(rails_reg);
            REG_MODE:  prdata = APB_DATA_W'(decrypt_mode_reg);
            default:   prdata = '0;
        endcase
    end

    // The controller sequences loading, the zigzag walk and the decrypt scan.
    rft_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .last_in (last_in),
        .st      (st),
        .busy    (busy),
        .cmd     (cmd)
    );

    // The datapath holds the message memories, the walk counters and the
    // result register.
    rft_datapath #(
        .MAX_LEN   (MAX_LEN),
        .MAX_RAILS (MAX_RAILS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .char_in      (char_in),
        .last_in      (last_in),
        .rails        (rails_reg),
        .decrypt_mode (decrypt_mode_reg),
        .char_out     (char_out),
        .last_out     (last_out),
        .out_valid    (out_valid)
    );

endmodule

`default_nettype wire

// File: test/tb_rail_fence_transposer_unit.sv
// Self-checking testbench for the rail fence transposer unit.
`timescale 1ns / 100ps

// Tracks the message being loaded, the rail count and the mode, and computes the
// word sequence that the unit must emit when a message is closed.
class transposition_tracker;
    typedef struct {
        logic [rft_pkg::CHAR_W-1:0] ch;
        logic                       last;
    } out_word_t;

    logic [rft_pkg::CHAR_W-1:0]  message [rft_pkg::MAX_LEN_DEF];
    int                          stored_len;
    logic [rft_pkg::RAILS_W-1:0] rail_count;
    logic                        decrypt;
    out_word_t                   pending_cipher_words[$];
    int                          fail_count;

    function new();
        stored_len = 0;
        rail_count = rft_pkg::RAILS_RST;
        decrypt    = rft_pkg::MODE_RST;
        fail_count = 0;
    endfunction

    function int pending();
        return pending_cipher_words.size();
    endfunction

    function void set_register(logic idx, logic [rft_pkg::APB_DATA_W-1:0] value);
        if (idx == rft_pkg::REG_RAILS)
            rail_count = value[rft_pkg::RAILS_W-1:0];
        else
            decrypt = value[0];
    endfunction

    // Called for every word the unit accepts.
    function void accept_word(logic [rft_pkg::CHAR_W-1:0] ch, logic last);
        int                         k;
        int                         n;
        int                         period;
        int                         row;
        int                         pos;
        int                         rail;
        int                         slot;
        int                         j;
        int                         source_pos [rft_pkg::MAX_LEN_DEF];
        logic [rft_pkg::CHAR_W-1:0] permuted [rft_pkg::MAX_LEN_DEF];
        out_word_t                  w;

        if (ch != '0 && stored_len < rft_pkg::MAX_LEN_DEF)
        begin
            message[stored_len] = ch;
            stored_len++;
        end
        if (!last)
            return;

        n = stored_len;
        stored_len = 0;
        if (n == 0)
            return;

        k = rail_count;
        if (k < 1)
            k = 1;
        if (k > rft_pkg::MAX_RAILS_DEF)
            k = rft_pkg::MAX_RAILS_DEF;
        period = 2 * (k - 1);

        // Collect message positions rail by rail to get the encrypt order.
        slot = 0;
        for (row = 0; row < k; row++)
        begin
            for (pos = 0; pos < n; pos++)
            begin
                rail = (k == 1) ? 0 : pos % period;
                if (rail >= k)
                    rail = period - rail;
                if (rail == row)
                begin
                    source_pos[slot] = pos;
                    slot++;
                end
            end
        end

        for (j = 0; j < n; j++)
        begin
            if (decrypt)
                permuted[source_pos[j]] = message[j];
            else
                permuted[j] = message[source_pos[j]];
        end

        for (j = 0; j < n; j++)
        begin
            w.ch   = permuted[j];
            w.last = (j == n - 1);
            pending_cipher_words.push_back(w);
        end
    endfunction

    // Called for every word the unit emits.
    function void check_word(logic [rft_pkg::CHAR_W-1:0] ch, logic last);
        out_word_t w;

        if (pending_cipher_words.size() == 0)
        begin
            $error("char_out: unexpected word, expected none, actual 0x%02h (last_out %0b)",
                   ch, last);
            fail_count++;
            return;
        end
        w = pending_cipher_words.pop_front();
        if (ch !== w.ch)
        begin
            $error("char_out mismatch: expected 0x%02h, actual 0x%02h", w.ch, ch);
            fail_count++;
        end
        if (last !== w.last)
        begin
            $error("last_out mismatch: expected %0b, actual %0b", w.last, last);
            fail_count++;
        end
    endfunction
endclass

module tb_rail_fence_transposer_unit;
    import rft_pkg::*;

    // After a burst the unit may still be busy with the walk, settling and scan in
    // decrypt mode, and an empty message gives nothing to wait on, so every quiet
    // point waits DRAIN_CYCLES before touching the registers.
    localparam int DRAIN_CYCLES = 2 * MAX_LEN_DEF + 8;
    // Far above the slowest legal run: about 120 words, each burst bounded by its
    // walk and scan, an idle chance of at most 75 percent, a drain per phase.
    localparam int CYCLE_LIMIT  = 200000;
    // Words sent in each random phase; a message may overshoot it.
    localparam int PHASE_WORDS  = 3;

    logic                  clk;
    logic                  rst_n   = 1'b0;
    logic                  start   = 1'b0;
    logic                  busy;
    logic [CHAR_W-1:0]     char_in = '0;
    logic                  last_in = 1'b0;
    logic                  out_valid;
    logic [CHAR_W-1:0]     char_out;
    logic                  last_out;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int cycle_count = 0;

    transposition_tracker tracker = new();

    rail_fence_transposer_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .char_in   (char_in),
        .last_in   (last_in),
        .out_valid (out_valid),
        .char_out  (char_out),
        .last_out  (last_out),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Observe both channels at each rising edge. The unit updates its outputs
    // through nonblocking assignments, so the values read here are the ones
    // that were stable during the cycle that this edge closes. A word counts as
    // accepted when start was high and busy low; a result counts when out_valid
    // was high, since the receiver has no way to stall the unit.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                tracker.accept_word(char_in, last_in);
            if (out_valid)
                tracker.check_word(char_out, last_out);
        end
    end

    // Present one word and hold it until the unit takes it. The loop exits at
    // the edge where busy was low, which is the edge that accepted the word.
    // start is left high so that back-to-back words need no extra cycle.
    task automatic send_word(input logic [CHAR_W-1:0] ch, input logic last);
        start   <= 1'b1;
        char_in <= ch;
        last_in <= last;
        do @(posedge clk); while (busy);
    endtask

    // The sender goes quiet for a few cycles; the data lines carry junk that
    // the unit must ignore while start is low.
    task automatic pause_sender(input int cycles);
        start   <= 1'b0;
        char_in <= CHAR_W'($urandom);
        last_in <= 1'($urandom);
        repeat (cycles) @(posedge clk);
    endtask

    task automatic send_bytes(input logic [CHAR_W-1:0] msg[$]);
        int i;

        for (i = 0; i < msg.size(); i++)
            send_word(msg[i], i == msg.size() - 1);
    endtask

    // A message of len words with random content. Some words are zero bytes,
    // which the unit must drop, the closing word included. Each cycle before a
    // word the sender stays idle with the given chance, so gaps land both in
    // loading and during a burst.
    task automatic send_message(input int len, input int gap_pct, input int zero_pct);
        logic [CHAR_W-1:0] ch;
        int                i;

        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(99, 0) < zero_pct)
                ch = '0;
            else
                ch = CHAR_W'($urandom_range(255, 1));
            while ($urandom_range(99, 0) < gap_pct)
                pause_sender(1);
            send_word(ch, i == len - 1);
        end
    endtask

    // Bring the unit to rest: stop sending, wait for every predicted word,
    // then allow for a burst that produces nothing to wait on.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (tracker.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle until pready. The unused
    // upper data bits carry random values, which the register must ignore.
    task automatic cfg_write(input logic idx, input logic [RAILS_W-1:0] value);
        logic [APB_DATA_W-1:0] data;

        data = $urandom;
        if (idx == REG_RAILS)
            data[RAILS_W-1:0] = value;
        else
            data[0] = value[0];
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_register(idx, data);
    endtask

    task automatic configure(input logic [RAILS_W-1:0] rails, input logic decrypt);
        settle();
        cfg_write(REG_RAILS, rails);
        cfg_write(REG_MODE, RAILS_W'(decrypt));
    endtask

    // Watchdog: ends the run as failed if the stimulus or the drain hangs.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int            phase;
        int            sent;
        int            len;
        int            gap_pct;
        logic [RAILS_W-1:0] rails;
        logic          decrypt;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, starting from the reset setting of three rails, encrypt.
        // A message longer than the rail count, so the zigzag bounces, with the
        // smallest and largest byte values and both values of the top bit.
        send_bytes({8'h01, 8'hFF, 8'h80, 8'h7F, 8'h55});
        // A closing zero byte on an empty message gives no results.
        send_bytes({8'h00});
        // A one-byte message.
        send_bytes({8'hAA});
        // A zero byte in the middle is dropped, and a closing zero byte still
        // releases what was stored before it.
        send_bytes({8'h11, 8'h00, 8'h22, 8'h00});
        // One rail is the identity, and zero rails behave as one.
        configure(5'd1, 1'b0);
        send_bytes({8'hC3, 8'h3C, 8'h0F});
        configure(5'd0, 1'b0);
        send_bytes({8'hF0, 8'h0E, 8'h01});
        // The largest register value saturates; with at least as many rails as
        // bytes the zigzag never bounces, so decrypt is the identity too.
        configure(5'd31, 1'b1);
        send_bytes({8'h12, 8'h34, 8'h56, 8'h78});
        // Two rails in decrypt mode, the smallest count that permutes.
        configure(5'd2, 1'b1);
        send_bytes({8'hA5, 8'h5A, 8'h96, 8'h69, 8'hE7});

        // Random part. Each phase picks a setting and an idling pattern: no
        // gaps, or the sender idle with a chance of 75 percent or of 20 percent.
        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:
                begin
                    rails   = 5'd2;
                    decrypt = 1'b0;
                end
                1:
                begin
                    rails   = 5'd16;
                    decrypt = 1'b1;
                end
                2:
                begin
                    rails   = 5'd5;
                    decrypt = 1'b1;
                end
                3:
                begin
                    rails   = 5'd4;
                    decrypt = 1'b0;
                end
                default:
                begin
                    rails   = RAILS_W'($urandom_range(31, 0));
                    decrypt = 1'($urandom);
                end
            endcase
            case (phase % 3)
                0:       gap_pct = 0;
                1:       gap_pct = 75;
                default: gap_pct = 20;
            endcase
            configure(rails, decrypt);

            sent = 0;
            // Past MAX_LEN bytes the rest is dropped, and the burst is the
            // longest the unit can produce, at the maximum rail count.
            if (phase == 1)
            begin
                send_message(MAX_LEN_DEF + 2, gap_pct, 0);
                sent = MAX_LEN_DEF + 2;
            end
            while (sent < PHASE_WORDS)
            begin
                if ($urandom_range(4, 0) == 0)
                    len = $urandom_range(12, 8);
                else
                    len = $urandom_range(4, 1);
                send_message(len, gap_pct, 8);
                sent += len;
            end
        end

        // Wait for every predicted word, then for any stray output.
        settle();
        if (tracker.fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
